@@ hw/rtl/ihb_pkg.sv @@
// Shared types and constants for the integral histogram builder.
// No dependencies; imported by every module of the block.
package ihb_pkg;

  // Default sizing for the top-level parameters
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_BINS  = 16;

  // Field widths
  localparam int PIX_W     = 8;
  localparam int COUNT_W   = 21;
  localparam int ROW_CNT_W = 11;
  localparam int BIN_NUM_W = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 11;
  localparam int WIDTH_W   = 11;
  localparam int BINS_W    = 5;
  localparam int BW_W      = 9;
  localparam int LO_W      = 10;

  localparam logic [COUNT_W-1:0]   COUNT_MAX   = '1;
  localparam logic [ROW_CNT_W-1:0] ROW_CNT_MAX = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE = 1'd1;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd640;
  localparam logic [BINS_W-1:0]  BINS_RESET  = 5'd16;

  // Bin width floor(256 / n) for n = 0..64; entry 0 is never used
  localparam int BW_TABLE_DEPTH = 65;
  localparam int BW_IDX_W       = 7;
  localparam logic [BW_W-1:0] BW_TABLE [BW_TABLE_DEPTH] = '{
    9'd256, 9'd256, 9'd128, 9'd85,  9'd64,  9'd51,  9'd42,  9'd36,
    9'd32,  9'd28,  9'd25,  9'd23,  9'd21,  9'd19,  9'd18,  9'd17,
    9'd16,  9'd15,  9'd14,  9'd13,  9'd12,  9'd12,  9'd11,  9'd11,
    9'd10,  9'd10,  9'd9,   9'd9,   9'd9,   9'd8,   9'd8,   9'd8,
    9'd8,   9'd7,   9'd7,   9'd7,   9'd7,   9'd6,   9'd6,   9'd6,
    9'd6,   9'd6,   9'd6,   9'd5,   9'd5,   9'd5,   9'd5,   9'd5,
    9'd5,   9'd5,   9'd5,   9'd5,   9'd4,   9'd4,   9'd4,   9'd4,
    9'd4,   9'd4,   9'd4,   9'd4,   9'd4,   9'd4,   9'd4,   9'd4,
    9'd4
  };

  // Controller to datapath
  typedef struct packed {
    logic accept;  // load a new pixel word
    logic issue;   // start work on the current bin
  } ihb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic busy;        // a bin is in the update stage
    logic space;       // output queue can take one more bin
    logic last_issue;  // current bin is the last one in use
  } ihb_status_t;

endpackage

@@ hw/rtl/ihb_ctrl.sv @@
// Controller for the integral histogram builder: pixel acceptance and
// bin sequencing. Depends on ihb_pkg.
module ihb_ctrl
  import ihb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  ihb_status_t status,
  output ihb_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;

  // Take a pixel only when idle and the update stage has drained
  assign in_stall   = rst || (state != ST_IDLE) || status.busy;
  assign cmd.accept = in_valid && !in_stall;
  assign cmd.issue  = (state == ST_RUN) && status.space;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.accept) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (cmd.issue && status.last_issue) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hw/rtl/ihb_datapath.sv @@
// Datapath for the integral histogram builder: configuration registers,
// row position, per-bin row counts, line store and output queue.
// Depends on ihb_pkg.
module ihb_datapath
  import ihb_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_BINS  = DEF_MAX_BINS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic [PIX_W-1:0]     pixel,
  input  logic                 frame_start,
  input  ihb_cmd_t             cmd,
  output ihb_status_t          status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BIN_NUM_W-1:0] bin_number,
  output logic [COUNT_W-1:0]   region_count,
  output logic                 last_bin
);

  localparam int CW1       = $clog2(MAX_WIDTH + 1);
  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int BCW       = $clog2(MAX_BINS + 1);
  localparam int BIW       = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int MEM_DEPTH = MAX_WIDTH * MAX_BINS;
  localparam int AW        = $clog2(MEM_DEPTH);

  typedef struct packed {
    logic [BIN_NUM_W-1:0] bin;
    logic [COUNT_W-1:0]   count;
    logic                 last;
  } out_word_t;

  // Configuration registers
  logic [WIDTH_W-1:0] width_reg;
  logic [BINS_W-1:0]  bins_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg <= WIDTH_RESET;
      bins_reg  <= BINS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: width_reg <= cfg_data;
        REG_BINS_IN_USE: bins_reg  <= cfg_data[BINS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp registers into the supported range
  logic [CW1-1:0] width_eff;
  logic [BCW-1:0] bins_eff;

  always_comb begin
    if (width_reg == '0) width_eff = CW1'(1);
    else if (32'(width_reg) > MAX_WIDTH) width_eff = CW1'(MAX_WIDTH);
    else width_eff = CW1'(width_reg);
    if (bins_reg == '0) bins_eff = BCW'(1);
    else if (32'(bins_reg) > MAX_BINS) bins_eff = BCW'(MAX_BINS);
    else bins_eff = BCW'(bins_reg);
  end

  // Row position and per-pixel working registers
  logic [CW1-1:0]     col;
  logic               first_row;
  logic [CW-1:0]      cur_col;
  logic [PIX_W-1:0]   pix_cur;
  logic [BCW-1:0]     bins_cur;
  logic [BW_W-1:0]    bw_cur;
  logic [BIW-1:0]     b_idx;
  logic [LO_W-1:0]    lo;
  logic               row_start;
  logic [CW-1:0]      col_used;

  assign row_start = frame_start || (col >= width_eff);
  assign col_used  = row_start ? '0 : CW'(col);

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      first_row <= 1'b1;
    end else if (cmd.accept) begin
      col <= CW1'(col_used) + CW1'(1);
      if (frame_start) first_row <= 1'b1;
      else if (row_start) first_row <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_col  <= col_used;
      pix_cur  <= pixel;
      bins_cur <= bins_eff;
      bw_cur   <= BW_TABLE[BW_IDX_W'(bins_eff)];
      b_idx    <= '0;
      lo       <= '0;
    end else if (cmd.issue) begin
      b_idx <= b_idx + BIW'(1);
      lo    <= lo + LO_W'(bw_cur);
    end
  end

  // Bin range test for the bin being issued
  logic issue_last;
  logic issue_hit;

  assign issue_last = (BCW'(b_idx) == (bins_cur - BCW'(1)));
  assign issue_hit  = (LO_W'(pix_cur) >= lo) &&
                      (issue_last || (LO_W'(pix_cur) < (lo + LO_W'(bw_cur))));

  // Line store of the row above: one read and one write port
  logic [COUNT_W-1:0] store [MEM_DEPTH];
  logic [COUNT_W-1:0] store_rd;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [COUNT_W-1:0] wr_data;

  assign rd_addr = AW'(cur_col) * AW'(MAX_BINS) + AW'(b_idx);

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_addr] <= wr_data;
    if (cmd.issue) store_rd <= store[rd_addr];
  end

  // Update stage registers
  logic           s1_valid;
  logic [BIW-1:0] s1_bin;
  logic           s1_hit;
  logic           s1_last;
  logic [AW-1:0]  s1_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      s1_bin  <= b_idx;
      s1_hit  <= issue_hit;
      s1_last <= issue_last;
      s1_addr <= rd_addr;
    end
  end

  // Running per-bin counts of the current row; invalid entries read as zero
  logic [ROW_CNT_W-1:0] row_cnt [MAX_BINS];
  logic [MAX_BINS-1:0]  row_vld;
  logic [ROW_CNT_W-1:0] rc_old;
  logic [ROW_CNT_W-1:0] rc_new;
  logic [COUNT_W-1:0]   up_cnt;
  logic [COUNT_W:0]     sum;
  logic [COUNT_W-1:0]   cnt;

  always_comb begin
    rc_old = row_vld[s1_bin] ? row_cnt[s1_bin] : '0;
    rc_new = (s1_hit && (rc_old != ROW_CNT_MAX)) ? rc_old + ROW_CNT_W'(1) : rc_old;
    up_cnt = first_row ? '0 : store_rd;
    sum    = (COUNT_W+1)'(up_cnt) + (COUNT_W+1)'(rc_new);
    cnt    = (sum > (COUNT_W+1)'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];
  end

  assign wr_en   = s1_valid;
  assign wr_addr = s1_addr;
  assign wr_data = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (cmd.accept && row_start) begin
      row_vld <= '0;
    end else if (s1_valid) begin
      row_vld[s1_bin] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) row_cnt[s1_bin] <= rc_new;
  end

  // Two-word output queue
  out_word_t fifo_mem [2];
  logic      wr_ptr;
  logic      rd_ptr;
  logic [1:0] fifo_cnt;
  logic      push;
  logic      pop;
  out_word_t head;

  assign push = s1_valid;
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
      fifo_cnt <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      fifo_cnt <= fifo_cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_mem[wr_ptr] <= '{bin: BIN_NUM_W'(s1_bin), count: cnt, last: s1_last};
  end

  assign head         = fifo_mem[rd_ptr];
  assign out_valid    = (fifo_cnt != '0);
  assign bin_number   = head.bin;
  assign region_count = head.count;
  assign last_bin     = head.last;

  // Room for one more bin once queued and in-flight words are counted
  assign status.busy       = s1_valid;
  assign status.space      = ((fifo_cnt + 2'(s1_valid) - 2'(pop)) < 2'd2);
  assign status.last_issue = issue_last;

endmodule

@@ hw/rtl/integral_histogram_builder.sv @@
// Integral histogram builder: each 8-bit pixel, taken in raster order, is
// binned into one of bins_in_use bins (width floor(256/bins), last bin takes
// the rest), and for every bin in use one word goes out, in bin order, with
// the count of that bin's pixels in the rectangle from the frame origin to
// this pixel; last_bin marks the final word of a pixel. frame_start restarts
// row and column. Each pixel is taken, then the line store's single read port
// serves one bin per cycle while the output queue has room, and the update
// stage drains before the next pixel is taken. The line store holds
// MAX_WIDTH * MAX_BINS 21-bit counts and is never cleared; its words are
// used only after the row above wrote them. Counts saturate at 2097151.
// Configuration writes are taken at any time outside reset but must only be
// issued while the block is idle. Depends on ihb_pkg, ihb_ctrl, ihb_datapath.
module integral_histogram_builder
  import ihb_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_BINS  = DEF_MAX_BINS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     pixel,
  input  logic                 frame_start,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BIN_NUM_W-1:0] bin_number,
  output logic [COUNT_W-1:0]   region_count,
  output logic                 last_bin
);

  ihb_cmd_t    cmd;
  ihb_status_t status;

  // Accept configuration words outside reset
  assign cfg_ready = !rst;

  ihb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ihb_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_BINS  (MAX_BINS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel        (pixel),
    .frame_start  (frame_start),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .bin_number   (bin_number),
    .region_count (region_count),
    .last_bin     (last_bin)
  );

endmodule

@@ hw/rtl/ihb_checker.sv @@
// Port-level checks for the integral histogram builder, bound to the top.
// Depends on ihb_pkg and integral_histogram_builder.
module ihb_checker
  import ihb_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [BIN_NUM_W-1:0] bin_number,
  input logic [COUNT_W-1:0]   region_count,
  input logic                 last_bin
);

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(bin_number) &&
      $stable(region_count) && $stable(last_bin))
    else $error("output word changed while stalled");

  // Drop all output words on reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // The input stalls in the cycle after a pixel word is accepted
  a_no_back_to_back: assert property (@(posedge clk)
    in_valid && !in_stall |=> in_stall)
    else $error("pixel words accepted on consecutive cycles");

endmodule

bind integral_histogram_builder ihb_checker u_ihb_checker (.*);
